### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console cell writer: transaction
// payloads, register indexes, item codes and the controller/datapath links.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // Default screen store geometry.
   localparam int MAX_COLS_DEF = 80;
   localparam int MAX_ROWS_DEF = 25;

   // Field widths.
   localparam int FUNC_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int COLOR_W = 4;
   localparam int CELL_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Cell layout.
   localparam int FG_SHIFT = 8;
   localparam int BG_SHIFT = 12;

   // Item codes.
   localparam logic [FUNC_W-1:0] FUNC_PRINT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_NEWLINE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FG_COLOR      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_COLOR      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 2'd3;

   // Register reset values.
   localparam logic [COLOR_W-1:0] FG_COLOR_RST      = 4'd15;
   localparam logic [COLOR_W-1:0] BG_COLOR_RST      = 4'd0;
   localparam logic [COL_W-1:0]   SCREEN_WIDTH_RST  = 7'd80;
   localparam logic [ROW_W-1:0]   SCREEN_HEIGHT_RST = 5'd25;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_code;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_col;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [ROW_W-1:0]  cursor_row;
      logic [COL_W-1:0]  cursor_col;
      logic [CELL_W-1:0] cell_value;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic init_step;
      logic load;
      logic calc;
      logic exec;
      logic copy_step;
      logic clear_step;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic init_done;
      logic need_scroll;
      logic copy_done;
      logic clear_done;
   } stat_type;

endpackage

### rtl/core/text_console_cell_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// Text-mode console store with a cursor: prints characters, handles
// newlines with scrolling, and returns cells for display fetch.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                              Direction  Completes when
//   --------  ---------------------------------  ---------  -------------------
//   request   start, busy, req_data              in         start && !busy
//   response  rsp_valid, rsp_data                out        every rsp_valid cycle
//   config    csr_wr_en, csr_index, csr_wr_data  in         every csr_wr_en cycle
//
// A print, newline or read transaction passes, from one accepted start to the
// next, through address calculation (one small multiply), execute (one
// store access), response, and the idle state that takes the next start.
// The response appears for one cycle.
// A newline or a wrapping print past the last row adds a scroll through the
// single read port and single write port of the screen store, which moves
// one cell per cycle and then clears the bottom row.
// After reset the store is cleared one cell per cycle, all MAX_COLS * MAX_ROWS
// cells, while busy stays high; configuration writes are taken throughout.
// The receiver cannot stall the response, so nothing else holds the block.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core #(
   parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // Request transactions.
   input  logic                            start,
   output logic                            busy,
   input  tcw_pkg::req_type                req_data,
   // Response transactions.
   output logic                            rsp_valid,
   output tcw_pkg::rsp_type                rsp_data,
   // Configuration writes.
   input  logic                            csr_wr_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]  csr_wr_data
);

   // The controller only sequences; every register that carries data,
   // including the cursor and the screen store, lives in the datapath.
   tcw_pkg::cmd_type  cmd;
   tcw_pkg::stat_type stat;

   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath drives the response fields from its registers at all times;
   // they are meaningful in the cycle that the controller marks with rsp_valid.
   tcw_datapath #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

endmodule

### rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer for the cell writer: reset clearing pass, item decode and
// execute, scroll copy and bottom row clear, and the response cycle.
// ----------------------------------------------------------------------------
module tcw_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  tcw_pkg::stat_type  stat,
   output logic               busy,
   output logic               rsp_valid,
   output tcw_pkg::cmd_type   cmd
);

   typedef enum logic [6:0] {
      ST_INIT  = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_CALC  = 7'b0000100,
      ST_EXEC  = 7'b0001000,
      ST_COPY  = 7'b0010000,
      ST_CLEAR = 7'b0100000,
      ST_RESP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_INIT: begin
            cmd.init_step = 1'b1;
            if (stat.init_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = stat.need_scroll ? ST_COPY : ST_RESP;
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (stat.copy_done) state_in = ST_CLEAR;
         end
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

### rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, configuration registers, address arithmetic and the
// scroll pointers of the cell writer.
// ----------------------------------------------------------------------------
module tcw_datapath #(
   parameter int MAX_COLS = tcw_pkg::MAX_COLS_DEF,
   parameter int MAX_ROWS = tcw_pkg::MAX_ROWS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tcw_pkg::cmd_type                   cmd,
   output tcw_pkg::stat_type                  stat,
   input  tcw_pkg::req_type                   req_data,
   output tcw_pkg::rsp_type                   rsp_data,
   input  logic                               csr_wr_en,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int ROW_W = tcw_pkg::ROW_W;
   localparam int COL_W = tcw_pkg::COL_W;
   localparam int SUM_W = ROW_W + COL_W + 1;

   logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

   tcw_pkg::req_type             item_ff;
   logic                         reject_ff, reject_in;
   logic [AW-1:0]                addr_ff;
   logic [ROW_W-1:0]             cur_row_ff, cur_row_in;
   logic [COL_W-1:0]             cur_col_ff, cur_col_in;
   logic [tcw_pkg::COLOR_W-1:0]  fg_ff, bg_ff;
   logic [COL_W-1:0]             width_ff;
   logic [ROW_W-1:0]             height_ff;
   logic [CW-1:0]                total_ff;
   logic [CW-1:0]                src_ff, dst_ff;
   logic                         pend_ff;
   logic [AW-1:0]                init_ptr_ff;
   logic [tcw_pkg::CELL_W-1:0]   rd_data_ff;

   logic [COL_W-1:0]             eff_w;
   logic [ROW_W-1:0]             eff_h;
   logic [ROW_W-1:0]             row_sel;
   logic [COL_W-1:0]             col_sel;
   logic [SUM_W-1:0]             addr_sum;
   logic [COL_W:0]               col_inc;
   logic [ROW_W:0]               row_inc;
   logic                         wrap, row_ovf, do_print, scroll;
   logic                         src_live, dst_live;
   logic                         we, re;
   logic [AW-1:0]                waddr, raddr;
   logic [tcw_pkg::CELL_W-1:0]   wdata, new_cell;

   // Geometry beyond the store acts as the store's size.
   assign eff_w = (int'(width_ff) > MAX_COLS) ? COL_W'(MAX_COLS) : width_ff;
   assign eff_h = (int'(height_ff) > MAX_ROWS) ? ROW_W'(MAX_ROWS) : height_ff;

   assign row_sel  = (item_ff.func == tcw_pkg::FUNC_READ) ? item_ff.read_row : cur_row_ff;
   assign col_sel  = (item_ff.func == tcw_pkg::FUNC_READ) ? item_ff.read_col : cur_col_ff;
   assign addr_sum = SUM_W'(eff_w) * SUM_W'(row_sel) + SUM_W'(col_sel);

   always_comb begin
      case (item_ff.func)
         tcw_pkg::FUNC_PRINT:   reject_in = (cur_col_ff >= eff_w) || (cur_row_ff >= eff_h);
         tcw_pkg::FUNC_NEWLINE: reject_in = 1'b0;
         tcw_pkg::FUNC_READ:    reject_in = (item_ff.read_row >= eff_h) ||
                                            (item_ff.read_col >= eff_w);
         default:               reject_in = 1'b1;
      endcase
   end

   // Cursor movement for the execute cycle.
   assign col_inc  = {1'b0, cur_col_ff} + 1'b1;
   assign row_inc  = {1'b0, cur_row_ff} + 1'b1;
   assign wrap     = (col_inc >= {1'b0, eff_w});
   assign row_ovf  = (row_inc >= {1'b0, eff_h});
   assign do_print = (item_ff.func == tcw_pkg::FUNC_PRINT) && !reject_ff;

   always_comb begin
      cur_row_in = cur_row_ff;
      cur_col_in = cur_col_ff;
      scroll     = 1'b0;
      if ((do_print && wrap) || (item_ff.func == tcw_pkg::FUNC_NEWLINE)) begin
         cur_col_in = '0;
         scroll     = row_ovf;
         if (!row_ovf) cur_row_in = row_inc[ROW_W-1:0];
      end else if (do_print) begin
         cur_col_in = col_inc[COL_W-1:0];
      end
   end

   assign new_cell = tcw_pkg::CELL_W'(item_ff.char_code)
                   | (tcw_pkg::CELL_W'(fg_ff) << tcw_pkg::FG_SHIFT)
                   | (tcw_pkg::CELL_W'(bg_ff) << tcw_pkg::BG_SHIFT);

   assign src_live = (src_ff < total_ff);
   assign dst_live = (dst_ff < total_ff);

   // Single write port and single read port of the screen store.
   always_comb begin
      we    = 1'b0;
      re    = 1'b0;
      waddr = addr_ff;
      raddr = addr_ff;
      wdata = '0;
      if (cmd.init_step) begin
         we    = 1'b1;
         waddr = init_ptr_ff;
      end else if (cmd.exec) begin
         we    = do_print;
         wdata = new_cell;
         re    = (item_ff.func == tcw_pkg::FUNC_READ) && !reject_ff;
      end else if (cmd.copy_step) begin
         re    = src_live;
         raddr = src_ff[AW-1:0];
         we    = pend_ff;
         waddr = dst_ff[AW-1:0];
         wdata = rd_data_ff;
      end else if (cmd.clear_step) begin
         we    = dst_live;
         waddr = dst_ff[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rd_data_ff <= mem[raddr];
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         init_ptr_ff <= '0;
         pend_ff     <= 1'b0;
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         fg_ff       <= tcw_pkg::FG_COLOR_RST;
         bg_ff       <= tcw_pkg::BG_COLOR_RST;
         width_ff    <= tcw_pkg::SCREEN_WIDTH_RST;
         height_ff   <= tcw_pkg::SCREEN_HEIGHT_RST;
      end else begin
         if (cmd.init_step) init_ptr_ff <= init_ptr_ff + 1'b1;
         if (cmd.exec) begin
            cur_row_ff <= cur_row_in;
            cur_col_ff <= cur_col_in;
            pend_ff    <= 1'b0;
         end else if (cmd.copy_step) begin
            pend_ff <= src_live;
         end
         if (csr_wr_en) begin
            case (csr_index)
               tcw_pkg::CSR_FG_COLOR:      fg_ff     <= csr_wr_data[tcw_pkg::COLOR_W-1:0];
               tcw_pkg::CSR_BG_COLOR:      bg_ff     <= csr_wr_data[tcw_pkg::COLOR_W-1:0];
               tcw_pkg::CSR_SCREEN_WIDTH:  width_ff  <= csr_wr_data[COL_W-1:0];
               tcw_pkg::CSR_SCREEN_HEIGHT: height_ff <= csr_wr_data[ROW_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      total_ff <= CW'(eff_w) * CW'(eff_h);
      if (cmd.load) item_ff <= req_data;
      if (cmd.calc) begin
         addr_ff   <= AW'(addr_sum);
         reject_ff <= reject_in;
      end
      if (cmd.exec) begin
         src_ff <= CW'(eff_w);
         dst_ff <= '0;
      end else if (cmd.copy_step) begin
         if (src_live) src_ff <= src_ff + 1'b1;
         if (pend_ff)  dst_ff <= dst_ff + 1'b1;
      end else if (cmd.clear_step) begin
         if (dst_live) dst_ff <= dst_ff + 1'b1;
      end
   end

   assign stat.init_done   = (init_ptr_ff == AW'(DEPTH - 1));
   assign stat.need_scroll = scroll;
   assign stat.copy_done   = !src_live && !pend_ff;
   assign stat.clear_done  = !dst_live;

   assign rsp_data.status     = reject_ff;
   assign rsp_data.cursor_row = cur_row_ff;
   assign rsp_data.cursor_col = cur_col_ff;
   assign rsp_data.cell_value = ((item_ff.func == tcw_pkg::FUNC_READ) && !reject_ff)
                              ? rd_data_ff : '0;

endmodule

### rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the cell writer's request and response sequencing.
// ----------------------------------------------------------------------------
module tcw_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input tcw_pkg::rsp_type rsp_data
);

   // A response belongs to a transaction that is still in progress.
   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("response outside a transaction");

   // An accepted request makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // Exactly one response per transaction, and the block is free after it.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!rsp_valid && !busy))
      else $error("response repeated or block still busy");

   // A rejected transaction never returns cell contents.
   a_reject_no_cell: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status) |-> (rsp_data.cell_value == '0))
      else $error("rejected transaction returned a cell");

endmodule

bind text_console_cell_writer_core tcw_checker u_tcw_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

### tb/tb_text_console_cell_writer_core.sv
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer_core
// Self-checking bench for the text console cell writer. A shadow screen
// with its own cursor and register copies predicts every response. The
// bench drives directed cases and then random traffic under several screen
// geometries, and compares each response field by field.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer_core;
   import tcw_pkg::*;

   localparam int MAX_COLS    = MAX_COLS_DEF;
   localparam int MAX_ROWS    = MAX_ROWS_DEF;
   localparam int CELL_COUNT  = MAX_COLS * MAX_ROWS;
   localparam int REQ_W       = $bits(req_type);
   // A full-size scroll moves about 2000 cells, and the clearing pass after
   // reset takes as long again. The watchdog allows several times that.
   localparam int STALL_LIMIT = 25000;

   // Codes that the package does not name.
   localparam logic [FUNC_W-1:0] FUNC_UNUSED     = 2'd3;
   localparam logic              STATUS_OK       = 1'b0;
   localparam logic              STATUS_REJECTED = 1'b1;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   req_type               req_data;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   // Shadow copy of the screen, the cursor and the registers.
   logic [CELL_W-1:0]  shadow_cells [0:CELL_COUNT-1];
   int unsigned        crow;
   int unsigned        ccol;
   logic [COLOR_W-1:0] fg_nib;
   logic [COLOR_W-1:0] bg_nib;
   logic [COL_W-1:0]   width_reg;
   logic [ROW_W-1:0]   height_reg;

   // Responses that are owed by the block, oldest first.
   rsp_type     expected_replies [$];
   int unsigned mismatch_count = 0;
   int unsigned replies_seen   = 0;
   int unsigned max_gap        = 8;
   int unsigned stalled_cycles = 0;

   text_console_cell_writer_core DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // -------------------------------------------------------------------------
   // Shadow screen. Geometry registers above the store size act as the
   // store size; cells never move when the width changes, so a cell is
   // always located with the width in force at the time of the access.
   // -------------------------------------------------------------------------
   function automatic int unsigned active_width();
      return (width_reg > MAX_COLS) ? MAX_COLS : int'(width_reg);
   endfunction

   function automatic int unsigned active_height();
      return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
   endfunction

   // Scroll up one row and blank the bottom row. With a zero width or
   // height there is nothing to move and nothing to clear.
   function automatic void shift_rows_up();
      int unsigned w;
      int unsigned h;
      w = active_width();
      h = active_height();
      for (int unsigned r = 1; r < h; r++)
         for (int unsigned c = 0; c < w; c++)
            shadow_cells[w * (r - 1) + c] = shadow_cells[w * r + c];
      if (h >= 1)
         for (int unsigned c = 0; c < w; c++)
            shadow_cells[w * (h - 1) + c] = '0;
   endfunction

   // A row that ends up at or past the height scrolls the screen and is
   // pulled back by one. When the cursor already sat below a shrunken
   // height, this leaves the row where it was.
   function automatic void line_feed();
      ccol = 0;
      crow = crow + 1;
      if (crow >= active_height()) begin
         shift_rows_up();
         crow = crow - 1;
      end
   endfunction

   function automatic rsp_type console_apply_item(input req_type item);
      rsp_type     reply;
      int unsigned w;
      int unsigned h;
      w = active_width();
      h = active_height();
      reply = '0;
      reply.status = STATUS_OK;
      case (item.func)
         FUNC_PRINT: begin
            // A cursor outside the screen refuses the print and stays put.
            if (ccol >= w || crow >= h) begin
               reply.status = STATUS_REJECTED;
            end else begin
               shadow_cells[w * crow + ccol] = {bg_nib, fg_nib, item.char_code};
               ccol = ccol + 1;
               if (ccol >= w)
                  line_feed();
            end
         end
         FUNC_NEWLINE: begin
            line_feed();
         end
         FUNC_READ: begin
            if (item.read_row >= h || item.read_col >= w)
               reply.status = STATUS_REJECTED;
            else
               reply.cell_value = shadow_cells[w * item.read_row + item.read_col];
         end
         default: begin
            reply.status = STATUS_REJECTED;
         end
      endcase
      reply.cursor_row = ROW_W'(crow);
      reply.cursor_col = COL_W'(ccol);
      return reply;
   endfunction

   function automatic void program_register(input logic [CSR_IDX_W-1:0] idx,
                                            input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_FG_COLOR:      fg_nib     = value[COLOR_W-1:0];
         CSR_BG_COLOR:      bg_nib     = value[COLOR_W-1:0];
         CSR_SCREEN_WIDTH:  width_reg  = value[COL_W-1:0];
         CSR_SCREEN_HEIGHT: height_reg = value[ROW_W-1:0];
         default: ;
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Transaction helpers.
   // -------------------------------------------------------------------------
   function automatic req_type compose_item(input logic [FUNC_W-1:0] f,
                                            input logic [CHAR_W-1:0] ch,
                                            input logic [ROW_W-1:0]  r,
                                            input logic [COL_W-1:0]  c);
      req_type item;
      item.func      = f;
      item.char_code = ch;
      item.read_row  = r;
      item.read_col  = c;
      return item;
   endfunction

   // Random item. The fields an operation ignores still carry random bits.
   // Most reads land inside the screen so that written cells get fetched;
   // the rest use the full field range and are mostly refused.
   function automatic req_type random_item(input int unsigned newline_pct);
      req_type     item;
      int unsigned pick;
      int unsigned w;
      int unsigned h;
      w = active_width();
      h = active_height();
      item = REQ_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < newline_pct) begin
         item.func = FUNC_NEWLINE;
      end else if (pick < newline_pct + 5) begin
         item.func = FUNC_UNUSED;
      end else if (pick < newline_pct + 30) begin
         item.func = FUNC_READ;
         if (w != 0 && h != 0 && $urandom_range(0, 4) != 0) begin
            item.read_row = ROW_W'($urandom_range(0, h - 1));
            item.read_col = COL_W'($urandom_range(0, w - 1));
         end
      end else begin
         item.func = FUNC_PRINT;
      end
      return item;
   endfunction

   // Sends one request transaction. The start line is left high on return,
   // so a following call with no gap presents its item at once; drain_replies,
   // or a following call with a gap, lowers it in the same time step.
   task automatic send_item(input req_type item);
      int unsigned gap;
      gap = $urandom_range(0, max_gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      expected_replies.push_back(console_apply_item(item));
   endtask

   // Waits until every owed response has come back. The queue is sampled on
   // the falling edge so that the check does not race the response checker.
   task automatic drain_replies();
      start <= 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0]  idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      program_register(idx, value);
      @(posedge clock);
   endtask

   task automatic set_geometry(input logic [CSR_DATA_W-1:0] w,
                               input logic [CSR_DATA_W-1:0] h);
      write_register(CSR_SCREEN_WIDTH, w);
      write_register(CSR_SCREEN_HEIGHT, h);
   endtask

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // -------------------------------------------------------------------------
   // Response checker. Every strobed response is matched against the oldest
   // prediction; the receiver cannot stall, so each strobe is one transaction.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : reply_checker
      rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         replies_seen++;
         if (expected_replies.size() == 0) begin
            flag_mismatch($sformatf("response %0d (%h) arrived with none owed",
                                    replies_seen, rsp_data));
         end else begin
            want = expected_replies.pop_front();
            if (rsp_data.status !== want.status)
               flag_mismatch($sformatf("response %0d status %b, expected %b",
                                       replies_seen, rsp_data.status, want.status));
            if (rsp_data.cursor_row !== want.cursor_row)
               flag_mismatch($sformatf("response %0d cursor_row %0d, expected %0d",
                                       replies_seen, rsp_data.cursor_row,
                                       want.cursor_row));
            if (rsp_data.cursor_col !== want.cursor_col)
               flag_mismatch($sformatf("response %0d cursor_col %0d, expected %0d",
                                       replies_seen, rsp_data.cursor_col,
                                       want.cursor_col));
            if (rsp_data.cell_value !== want.cell_value)
               flag_mismatch($sformatf("response %0d cell_value %h, expected %h",
                                       replies_seen, rsp_data.cell_value,
                                       want.cell_value));
         end
      end
   end

   // Watchdog: counts cycles in which no transaction completes on either
   // channel. The longest honest quiet stretch is a full-size scroll or the
   // clearing pass after reset.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1)
         stalled_cycles = 0;
      else
         stalled_cycles = stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("watchdog expired with %0d responses owed", expected_replies.size());
         $display("simulation failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Directed tests.
   // -------------------------------------------------------------------------

   // Reset geometry and colors: character bytes at both ends and with the
   // top bit set (must not sign extend), reads at the last cell, reads just
   // outside and at the far end of the fields, and the unused code.
   task automatic test_default_screen();
      send_item(compose_item(FUNC_PRINT, 8'h00, 5'd3, 7'd9));
      send_item(compose_item(FUNC_PRINT, 8'hFF, 5'd31, 7'd127));
      send_item(compose_item(FUNC_PRINT, 8'h80, 5'd0, 7'd0));
      send_item(compose_item(FUNC_READ, 8'hFF, 5'd0, 7'd1));
      send_item(compose_item(FUNC_READ, 8'h00, 5'd0, 7'd2));
      send_item(compose_item(FUNC_READ, 8'h5A, 5'd24, 7'd79));
      send_item(compose_item(FUNC_READ, 8'h00, 5'd25, 7'd0));
      send_item(compose_item(FUNC_READ, 8'h00, 5'd0, 7'd80));
      send_item(compose_item(FUNC_READ, 8'h00, 5'd31, 7'd127));
      send_item(compose_item(FUNC_UNUSED, 8'hA5, 5'd1, 7'd1));
      drain_replies();
   endtask

   // Extreme colors, and a width and height above the store size, which
   // must behave as the store size.
   task automatic test_color_and_oversize();
      write_register(CSR_FG_COLOR, 7'd0);
      write_register(CSR_BG_COLOR, 7'd15);
      set_geometry(7'd127, 7'd31);
      send_item(compose_item(FUNC_PRINT, 8'h41, 5'd0, 7'd0));
      send_item(compose_item(FUNC_READ, 8'h00, 5'd0, 7'd3));
      drain_replies();
   endtask

   // A narrow screen: the cursor starts outside it, a newline brings it
   // back, and a print that fills the last row wraps and scrolls.
   task automatic test_wrap_and_scroll();
      write_register(CSR_FG_COLOR, 7'd15);
      write_register(CSR_BG_COLOR, 7'd0);
      set_geometry(7'd2, 7'd2);
      send_item(compose_item(FUNC_PRINT, 8'h61, 5'd0, 7'd0));
      send_item(compose_item(FUNC_NEWLINE, 8'h00, 5'd0, 7'd0));
      send_item(compose_item(FUNC_PRINT, 8'h61, 5'd0, 7'd0));
      send_item(compose_item(FUNC_PRINT, 8'h62, 5'd0, 7'd0));
      send_item(compose_item(FUNC_READ, 8'h00, 5'd0, 7'd1));
      send_item(compose_item(FUNC_NEWLINE, 8'h00, 5'd0, 7'd0));
      drain_replies();
   endtask

   // Move the cursor down, then shrink the height under it: a newline
   // scrolls once and keeps the row, and a print is refused.
   task automatic test_shrunk_height();
      write_register(CSR_SCREEN_HEIGHT, 7'd5);
      repeat (3) send_item(compose_item(FUNC_NEWLINE, 8'h00, 5'd0, 7'd0));
      drain_replies();
      write_register(CSR_SCREEN_HEIGHT, 7'd2);
      send_item(compose_item(FUNC_NEWLINE, 8'h00, 5'd0, 7'd0));
      send_item(compose_item(FUNC_PRINT, 8'h7E, 5'd0, 7'd0));
      drain_replies();
   endtask

   // Zero width and height: prints and reads are refused, and a newline
   // still returns the column to zero without touching the store.
   task automatic test_zero_geometry();
      set_geometry(7'd0, 7'd0);
      send_item(compose_item(FUNC_PRINT, 8'h30, 5'd0, 7'd0));
      send_item(compose_item(FUNC_NEWLINE, 8'h00, 5'd0, 7'd0));
      send_item(compose_item(FUNC_READ, 8'h00, 5'd0, 7'd0));
      drain_replies();
   endtask

   // -------------------------------------------------------------------------
   // Random traffic. Each phase picks colors and a geometry while the block
   // is idle, then sends a burst. The first phase runs the full screen with
   // many newlines so that full-size scrolls happen; the second runs a one
   // cell screen; the rest mostly use small screens so that scrolls are
   // short, with an occasional odd or oversized one.
   // -------------------------------------------------------------------------
   task automatic test_random_traffic();
      int unsigned pick;
      int unsigned newline_pct;
      for (int phase = 0; phase < 10; phase++) begin
         write_register(CSR_FG_COLOR, CSR_DATA_W'($urandom_range(0, 127)));
         write_register(CSR_BG_COLOR, CSR_DATA_W'($urandom_range(0, 127)));
         newline_pct = 20;
         if (phase == 0) begin
            set_geometry(7'd80, 7'd25);
            newline_pct = 60;
         end else if (phase == 1) begin
            set_geometry(7'd1, 7'd1);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
               set_geometry(CSR_DATA_W'($urandom_range(0, 127)),
                            CSR_DATA_W'($urandom_range(1, 6)));
            else if (pick == 1)
               set_geometry(CSR_DATA_W'($urandom_range(1, 12)),
                            CSR_DATA_W'($urandom_range(0, 31)));
            else
               set_geometry(CSR_DATA_W'($urandom_range(1, 12)),
                            CSR_DATA_W'($urandom_range(1, 6)));
         end
         // Some phases send back to back; the rest idle at random.
         max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
         repeat (40) send_item(random_item(newline_pct));
         drain_replies();
         max_gap = 8;
      end
   endtask

   // -------------------------------------------------------------------------
   // Sequence.
   // -------------------------------------------------------------------------
   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      csr_wr_en   <= 1'b0;
      csr_index   <= '0;
      csr_wr_data <= '0;
      for (int i = 0; i < CELL_COUNT; i++)
         shadow_cells[i] = '0;
      crow       = 0;
      ccol       = 0;
      fg_nib     = FG_COLOR_RST;
      bg_nib     = BG_COLOR_RST;
      width_reg  = SCREEN_WIDTH_RST;
      height_reg = SCREEN_HEIGHT_RST;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_default_screen();
      test_color_and_oversize();
      test_wrap_and_scroll();
      test_shrunk_height();
      test_zero_geometry();
      test_random_traffic();

      // Let any stray response show up before the verdict.
      drain_replies();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### filelist.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_cell_writer_core.sv
rtl/core/tcw_checker.sv
tb/tb_text_console_cell_writer_core.sv
